// ----- rtl/bpc_pkg.sv -----
// ----------------------------------------------------------------------------
// bpc_pkg: shared types and constants for the box physics collision step
// Types, codes and constants used by the sequencer, ALU and top level.
// ----------------------------------------------------------------------------
`default_nettype none
package bpc_pkg;
  localparam int SLOTS = 16;
  localparam int SW = $clog2(SLOTS);
  localparam int VW = 24;
  localparam logic signed [VW-1:0] MAX24 = 24'sh7FFFFF;
  localparam logic signed [VW-1:0] MIN24 = -24'sh800000;
  localparam logic signed [VW-1:0] DEFAULT_BOX_SIZE = 24'sd12800;
  localparam logic signed [15:0] GRAVITY_RESET = 16'sd205;
  localparam logic [8:0] FRICTION_RESET = 9'd236;

  localparam logic [0:0] REG_GRAVITY = 1'b0;
  localparam logic [0:0] REG_FRICTION = 1'b1;

  localparam logic [3:0] K_TICK    = 4'd0;
  localparam logic [3:0] K_CREATE  = 4'd1;
  localparam logic [3:0] K_SETPOS  = 4'd2;
  localparam logic [3:0] K_SETSIZE = 4'd3;
  localparam logic [3:0] K_SETVX   = 4'd4;
  localparam logic [3:0] K_SETVY   = 4'd5;
  localparam logic [3:0] K_FLAGS   = 4'd6;
  localparam logic [3:0] K_FREEZE  = 4'd7;
  localparam logic [3:0] K_DESTROY = 4'd8;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FIND, ST_VEL, ST_FRIC, ST_MOVE, ST_SCAN, ST_BACK,
    ST_YMOVE, ST_EMIT, ST_WAIT
  } state_t;

  typedef enum logic [1:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_OVL
  } alu_op_t;

  typedef struct packed {
    alu_op_t op;
    logic signed [VW-1:0] a;
    logic signed [VW-1:0] b;
  } alu_req_t;

  function automatic logic signed [VW-1:0] sat24(input logic signed [VW+1:0] v);
    if (v > $signed({{2{1'b0}}, MAX24})) return MAX24;
    if (v < $signed({{2{1'b1}}, MIN24})) return MIN24;
    return v[VW-1:0];
  endfunction
endpackage
`default_nettype wire

// ----- rtl/bpc_alu.sv -----
// ----------------------------------------------------------------------------
// bpc_alu: shared arithmetic unit
// Saturating add/sub, friction multiply with floor shift, and a one-axis
// strict-overlap compare. Result registered.
// ----------------------------------------------------------------------------
`default_nettype none
module bpc_alu import bpc_pkg::*; (
  input  wire logic clk,
  input  wire alu_req_t req,
  input  wire logic signed [VW-1:0] ex_a,
  input  wire logic signed [VW-1:0] ex_b,
  output logic signed [VW-1:0] res_r,
  output logic ovl_r
);
  logic signed [VW-1:0] res_nxt;
  logic ovl_nxt;
  logic signed [VW+9:0] prod;
  logic signed [VW+1:0] d, ma, mb, sum;

  always_comb begin
    prod = $signed({{10{req.a[VW-1]}}, req.a}) * $signed({1'b0, req.b[8:0]});
    d = $signed({{2{req.a[VW-1]}}, req.a}) - $signed({{2{req.b[VW-1]}}, req.b});
    if (d[VW+1]) d = -d;
    ma = ex_a[VW-1] ? -$signed({{2{ex_a[VW-1]}}, ex_a}) : {2'b00, ex_a};
    mb = ex_b[VW-1] ? -$signed({{2{ex_b[VW-1]}}, ex_b}) : {2'b00, ex_b};
    sum = ma + mb;
    res_nxt = '0;
    ovl_nxt = 1'b0;
    unique case (req.op)
      OP_ADD: res_nxt = sat24($signed({{2{req.a[VW-1]}}, req.a}) +
                               $signed({{2{req.b[VW-1]}}, req.b}));
      OP_SUB: res_nxt = sat24($signed({{2{req.a[VW-1]}}, req.a}) -
                               $signed({{2{req.b[VW-1]}}, req.b}));
      OP_MUL: res_nxt = sat24(prod[VW+9:8]);
      OP_OVL: ovl_nxt = ({d[VW:0], 1'b0} < {1'b0, sum});
    endcase
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    ovl_r <= ovl_nxt;
  end
endmodule
`default_nettype wire

// ----- rtl/box_physics_collision_step.sv -----
// ----------------------------------------------------------------------------
// box_physics_collision_step: physics tick over a table of boxes
// Table of SLOTS centre-anchored boxes with write commands and a tick.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one command transaction. Write
//   kinds update one slot; the next transaction may follow on the next
//   cycle. A tick walks all slots in order; for each physics box it uses
//   one shared ALU: slot load and velocity update, x move, a scan of all
//   slots with one overlap axis compare per cycle (2 per slot), possible
//   move back, then the same on y, then a result transaction.
//   Output channel (out_valid/out_ready) carries one result per physics box,
//   last_of_tick set on the final one. The walk holds while a result is not
//   taken; in_ready is low until the whole tick is done.
//   Reset (rst_n low, synchronous) clears all slots and loads the default
//   gravity and friction registers. APB writes are to be made only while
//   idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none
module box_physics_collision_step import bpc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire logic [3:0] in_kind,
  input  wire logic [3:0] in_slot,
  input  wire logic signed [23:0] in_value_a,
  input  wire logic signed [23:0] in_value_b,
  input  wire logic in_set_physics,
  input  wire logic in_set_solid,
  output logic      out_valid,
  input  wire logic out_ready,
  output logic [3:0] out_object_slot,
  output logic signed [23:0] out_new_x,
  output logic signed [23:0] out_new_y,
  output logic signed [23:0] out_new_vx,
  output logic signed [23:0] out_new_vy,
  output logic out_last_of_tick,
  input  wire logic cfg_psel,
  input  wire logic cfg_penable,
  input  wire logic cfg_pwrite,
  input  wire logic [2:0] cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic cfg_pready
);
  logic signed [VW-1:0] bx [SLOTS], by [SLOTS], bw [SLOTS], bh [SLOTS];
  logic signed [VW-1:0] vx [SLOTS], vy [SLOTS];
  logic [SLOTS-1:0] used_r, phys_r, solid_r;
  logic signed [15:0] grav_r;
  logic [8:0] fric_r;

  state_t st_r, st_nxt;
  logic [SW-1:0] i_r, j_r;
  logic axis_r, hit_r, yph_r, last_r;
  logic signed [VW-1:0] cx_r, cy_r, cvx_r, cvy_r;

  alu_req_t req;
  logic signed [VW-1:0] ex_a, ex_b, alu_res;
  logic alu_ovl;

  bpc_alu u_alu (.clk(clk), .req(req), .ex_a(ex_a), .ex_b(ex_b),
                 .res_r(alu_res), .ovl_r(alu_ovl));

  logic pw;
  assign pw = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_FRICTION) cfg_prdata = {23'd0, fric_r};
    else cfg_prdata = {{16{grav_r[15]}}, grav_r};
  end

  logic [SLOTS-1:0] act;
  logic more;
  assign act = used_r & phys_r;
  always_comb begin
    more = 1'b0;
    for (int k = 0; k < SLOTS; k++)
      if (k > int'(i_r) && act[k]) more = 1'b1;
  end

  logic jv;
  assign jv = (j_r != i_r) && used_r[j_r] && solid_r[j_r];
  logic jend;
  assign jend = (j_r == SW'(SLOTS-1)) && axis_r;

  assign in_ready = (st_r == ST_IDLE);

  always_comb begin
    st_nxt = st_r;
    req.op = OP_ADD;
    req.a = '0;
    req.b = '0;
    ex_a = '0;
    ex_b = '0;
    unique case (st_r)
      ST_IDLE: if (in_valid && in_kind == K_TICK) st_nxt = ST_FIND;
      ST_FIND: if (act[i_r]) st_nxt = ST_VEL;
        else if (!more) st_nxt = ST_IDLE;
      ST_VEL: begin
        req.op = OP_ADD; req.a = vy[i_r];
        req.b = {{8{grav_r[15]}}, grav_r};
        st_nxt = ST_FRIC;
      end
      ST_FRIC: begin
        req.op = OP_MUL; req.a = vx[i_r]; req.b = {15'd0, fric_r};
        st_nxt = ST_MOVE;
      end
      ST_MOVE: begin
        req.op = OP_ADD;
        req.a = yph_r ? cy_r : cx_r;
        req.b = yph_r ? cvy_r : alu_res;
        st_nxt = ST_YMOVE;
      end
      ST_YMOVE: st_nxt = ST_SCAN;
      ST_SCAN: begin
        req.op = OP_OVL;
        req.a = axis_r ? by[j_r] : bx[j_r];
        req.b = axis_r ? cy_r : cx_r;
        ex_a = axis_r ? bh[j_r] : bw[j_r];
        ex_b = axis_r ? bh[i_r] : bw[i_r];
        if (jend) st_nxt = ST_BACK;
      end
      ST_BACK: begin
        req.op = OP_SUB;
        req.a = yph_r ? cy_r : cx_r;
        req.b = yph_r ? cvy_r : cvx_r;
        st_nxt = ST_WAIT;
      end
      ST_WAIT: st_nxt = yph_r ? ST_EMIT : ST_MOVE;
      ST_EMIT: if (out_ready) st_nxt = more ? ST_FIND : ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // overlap result lands in the cycle after issue, when axis_r has already flipped
  logic xok_r, pend_r, pj_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      used_r <= '0; phys_r <= '0; solid_r <= '0;
      grav_r <= GRAVITY_RESET; fric_r <= FRICTION_RESET;
      i_r <= '0; j_r <= '0; axis_r <= 1'b0; hit_r <= 1'b0; yph_r <= 1'b0;
      xok_r <= 1'b0; pend_r <= 1'b0; pj_r <= 1'b0; last_r <= 1'b0;
      for (int k = 0; k < SLOTS; k++) begin
        bx[k] <= '0; by[k] <= '0; bw[k] <= '0; bh[k] <= '0;
        vx[k] <= '0; vy[k] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      if (pw && cfg_paddr[2] == REG_GRAVITY) grav_r <= cfg_pwdata[15:0];
      if (pw && cfg_paddr[2] == REG_FRICTION) fric_r <= cfg_pwdata[8:0];
      pend_r <= (st_r == ST_SCAN);
      if (pend_r) begin
        if (axis_r) xok_r <= alu_ovl;
        else if (xok_r && alu_ovl && pj_r) hit_r <= 1'b1;
      end
      unique case (st_r)
        ST_IDLE: if (in_valid) begin
          i_r <= '0;
          if (in_kind != K_TICK && (SLOTS >= 16 || int'(in_slot) < SLOTS)) begin
            if (in_kind == K_CREATE && !used_r[SW'(in_slot)]) begin
              used_r[SW'(in_slot)] <= 1'b1;
              phys_r[SW'(in_slot)] <= 1'b0; solid_r[SW'(in_slot)] <= 1'b0;
              bx[SW'(in_slot)] <= '0; by[SW'(in_slot)] <= '0;
              bw[SW'(in_slot)] <= DEFAULT_BOX_SIZE;
              bh[SW'(in_slot)] <= DEFAULT_BOX_SIZE;
              vx[SW'(in_slot)] <= '0; vy[SW'(in_slot)] <= '0;
            end else if (used_r[SW'(in_slot)]) begin
              unique case (in_kind)
                K_SETPOS: begin bx[SW'(in_slot)] <= in_value_a;
                  by[SW'(in_slot)] <= in_value_b; end
                K_SETSIZE: begin bw[SW'(in_slot)] <= in_value_a;
                  bh[SW'(in_slot)] <= in_value_b; end
                K_SETVX: vx[SW'(in_slot)] <= in_value_a;
                K_SETVY: vy[SW'(in_slot)] <= in_value_a;
                K_FLAGS: begin
                  if (in_set_physics) phys_r[SW'(in_slot)] <= 1'b1;
                  if (in_set_solid) solid_r[SW'(in_slot)] <= 1'b1;
                end
                K_FREEZE: begin vx[SW'(in_slot)] <= '0; vy[SW'(in_slot)] <= '0; end
                K_DESTROY: begin
                  used_r[SW'(in_slot)] <= 1'b0; phys_r[SW'(in_slot)] <= 1'b0;
                  solid_r[SW'(in_slot)] <= 1'b0;
                  bx[SW'(in_slot)] <= '0; by[SW'(in_slot)] <= '0;
                  bw[SW'(in_slot)] <= '0; bh[SW'(in_slot)] <= '0;
                  vx[SW'(in_slot)] <= '0; vy[SW'(in_slot)] <= '0;
                end
                default: ;
              endcase
            end
          end
        end
        ST_FIND: begin
          cx_r <= bx[i_r]; cy_r <= by[i_r];
          yph_r <= 1'b0;
          if (!act[i_r] && more) i_r <= i_r + 1'b1;
        end
        ST_VEL: ;
        ST_FRIC: cvy_r <= alu_res;
        ST_MOVE: begin
          if (!yph_r) cvx_r <= alu_res;
          hit_r <= 1'b0; j_r <= '0; axis_r <= 1'b0;
        end
        ST_YMOVE: if (yph_r) cy_r <= alu_res; else cx_r <= alu_res;
        ST_SCAN: begin
          pj_r <= jv;
          axis_r <= !axis_r;
          if (axis_r) j_r <= j_r + 1'b1;
        end
        ST_BACK: ;
        ST_WAIT: begin
          if (hit_r) begin
            if (yph_r) begin cy_r <= alu_res; cvy_r <= '0; end
            else begin cx_r <= alu_res; cvx_r <= '0; end
          end
          yph_r <= 1'b1;
          if (yph_r) last_r <= !more;
        end
        ST_EMIT: if (out_ready) begin
          bx[i_r] <= cx_r; by[i_r] <= cy_r; vx[i_r] <= cvx_r; vy[i_r] <= cvy_r;
          if (more) i_r <= i_r + 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign out_valid = (st_r == ST_EMIT);
  assign out_object_slot = 4'(i_r);
  assign out_new_x = cx_r;
  assign out_new_y = cy_r;
  assign out_new_vx = cvx_r;
  assign out_new_vy = cvy_r;
  assign out_last_of_tick = last_r;
endmodule
`default_nettype wire

// ----- rtl/bpc_checker.sv -----
// ----------------------------------------------------------------------------
// bpc_checker: port-level checks for box_physics_collision_step
// Watches the channels and the register port over time.
// ----------------------------------------------------------------------------
`default_nettype none
module bpc_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_last_of_tick,
  input wire logic [23:0] out_new_x,
  input wire logic cfg_pready
);
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_new_x))
    else $error("result changed under stall");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("ready while reporting");
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_of_tick |=> in_ready)
    else $error("not idle after last result");
  a_pready: assert property (@(posedge clk) cfg_pready)
    else $error("pready low");
endmodule

bind box_physics_collision_step bpc_checker u_bpc_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .out_last_of_tick(out_last_of_tick), .out_new_x(out_new_x),
  .cfg_pready(cfg_pready));
`default_nettype wire
